/* rtl/tapc_pkg.sv */
// ----------------------------------------------------------------------------
// tapc_pkg: shared constants, codes and helpers of the triangle plane clipper
// Emission orders for each clip mode and the job layout widths.
// ----------------------------------------------------------------------------
package tapc_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned NORM_BITS      = 16;
  localparam int unsigned T_FRAC         = 24;
  localparam int unsigned T_BITS         = T_FRAC + 1;
  localparam int unsigned UNIT_LEN       = 16384;
  localparam int unsigned NRM_SHIFT      = 28;
  localparam int unsigned LEN2_BITS      = 32;
  localparam int unsigned ROOT_BITS      = 30;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CLIP_VALUE_RST = 16384;

  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_AXIS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_VALUE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEP_BELOW = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    MODE_PASS,
    MODE_ONE_BELOW,
    MODE_ONE_ABOVE,
    MODE_TWO_BELOW,
    MODE_TWO_ABOVE
  } mode_e;

  typedef enum logic [2:0] {
    SLOT_A,
    SLOT_B,
    SLOT_C,
    SLOT_P,
    SLOT_Q
  } slot_e;

  typedef struct packed {
    logic [1:0] count;
    logic       push;
  } front_stat_t;

  function automatic int unsigned vtx_bits(int unsigned cb);
    return 3 * cb + 3 * NORM_BITS;
  endfunction

  function automatic int unsigned job_bits(int unsigned cb);
    return 3 * vtx_bits(cb) + 3 + 2 + cb;
  endfunction

  function automatic logic [2:0] mode_len(mode_e m);
    logic [2:0] n;
    if (m == MODE_ONE_BELOW || m == MODE_TWO_ABOVE) begin
      n = 3'd6;
    end else begin
      n = 3'd3;
    end
    return n;
  endfunction

  function automatic slot_e mode_slot(mode_e m, logic [2:0] i);
    slot_e l [6];
    unique case (m)
      MODE_ONE_BELOW: l = '{SLOT_A, SLOT_P, SLOT_Q, SLOT_A, SLOT_Q, SLOT_C};
      MODE_ONE_ABOVE: l = '{SLOT_P, SLOT_B, SLOT_Q, SLOT_A, SLOT_A, SLOT_A};
      MODE_TWO_BELOW: l = '{SLOT_A, SLOT_P, SLOT_Q, SLOT_A, SLOT_A, SLOT_A};
      MODE_TWO_ABOVE: l = '{SLOT_P, SLOT_B, SLOT_Q, SLOT_Q, SLOT_B, SLOT_C};
      default:        l = '{SLOT_A, SLOT_B, SLOT_C, SLOT_A, SLOT_A, SLOT_A};
    endcase
    return (i < 3'd6) ? l[i] : SLOT_A;
  endfunction

endpackage

/* rtl/tapc_if.sv */
// ----------------------------------------------------------------------------
// tapc_if: channel interfaces of the triangle plane clipper
// Vertex input, vertex output and register write channels.
// ----------------------------------------------------------------------------
interface tapc_vtx_in_if import tapc_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] pos_x;
  logic signed [CoordBits-1:0] pos_y;
  logic signed [CoordBits-1:0] pos_z;
  logic signed [NORM_BITS-1:0] norm_x;
  logic signed [NORM_BITS-1:0] norm_y;
  logic signed [NORM_BITS-1:0] norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                output ready);
endinterface

interface tapc_vtx_out_if import tapc_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] out_x;
  logic signed [CoordBits-1:0] out_y;
  logic signed [CoordBits-1:0] out_z;
  logic signed [NORM_BITS-1:0] out_nx;
  logic signed [NORM_BITS-1:0] out_ny;
  logic signed [NORM_BITS-1:0] out_nz;
  logic                        is_new_corner;
  logic                        last;

  modport source (output valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                  is_new_corner, last, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                is_new_corner, last, output ready);
endinterface

interface tapc_cfg_if import tapc_pkg::*; #(
  parameter int unsigned DataBits = COORD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [DataBits-1:0]     wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/tapc_div.sv */
// ----------------------------------------------------------------------------
// tapc_div: restoring divider, one quotient bit per cycle
// Shared by the clip-fraction and normal-scaling steps.
// ----------------------------------------------------------------------------
module tapc_div import tapc_pkg::*; #(
  parameter int unsigned DivdBits = 44,
  parameter int unsigned DvsrBits = 30,
  parameter int unsigned QuotBits = T_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivdBits-1:0] dividend_i,
  input  logic [DvsrBits-1:0] divisor_i,
  output logic                done_o,
  output logic [QuotBits-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(DivdBits + 1);

  logic [DivdBits-1:0] num_q;
  logic [DvsrBits-1:0] den_q;
  logic [DvsrBits-1:0] rem_q;
  logic [QuotBits-1:0] quot_q;
  logic [CntBits-1:0]  cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [DvsrBits:0] rem_sh;
  logic [DvsrBits:0] diff;
  logic              ge;

  assign rem_sh = {rem_q, num_q[DivdBits-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(DivdBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= num_q << 1;
      rem_q  <= ge ? diff[DvsrBits-1:0] : rem_sh[DvsrBits-1:0];
      quot_q <= {quot_q[QuotBits-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* rtl/tapc_queue.sv */
// ----------------------------------------------------------------------------
// tapc_queue: small job queue between classifier and clip engine
// Register-based FIFO with valid/ready on both sides.
// ----------------------------------------------------------------------------
module tapc_queue import tapc_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q;
  logic [PtrBits-1:0] rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               push;
  logic               pop;

  assign push_ready_o = count_q != CntBits'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/tapc_front.sv */
// ----------------------------------------------------------------------------
// tapc_front: vertex collector and triangle classifier
// Holds two corners, classifies the triangle on the third and queues a job unless it is dropped.
// ----------------------------------------------------------------------------
module tapc_front import tapc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned JobBits = job_bits(COORD_BITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tapc_vtx_in_if.sink                  vtx_in_i,
  input  logic [1:0]                   clip_axis_i,
  input  logic signed [COORD_BITS-1:0] clip_value_i,
  input  logic                         keep_below_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output logic [JobBits-1:0]           job_o,
  output front_stat_t                  stat_o
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic signed [NORM_BITS-1:0]  nx;
    logic signed [NORM_BITS-1:0]  ny;
    logic signed [NORM_BITS-1:0]  nz;
  } vtx_t;

  typedef struct packed {
    vtx_t                         a;
    vtx_t                         b;
    vtx_t                         c;
    mode_e                        mode;
    logic [1:0]                   axis;
    logic signed [COORD_BITS-1:0] value;
  } job_t;

  function automatic logic signed [COORD_BITS-1:0] axis_coord(vtx_t v, logic [1:0] ax);
    logic signed [COORD_BITS-1:0] r;
    unique case (ax)
      AXIS_X:  r = v.px;
      AXIS_Y:  r = v.py;
      default: r = v.pz;
    endcase
    return r;
  endfunction

  logic [1:0] cnt_q;
  vtx_t       held0_q;
  vtx_t       held1_q;

  vtx_t       cur;
  vtx_t       v0;
  vtx_t       v1;
  logic [1:0] ax;
  logic [2:0] above;
  logic [1:0] n_above;
  logic [1:0] rot;
  logic       drop;
  logic       in_fire;
  job_t       job;

  assign cur = '{px: vtx_in_i.pos_x, py: vtx_in_i.pos_y, pz: vtx_in_i.pos_z,
                 nx: vtx_in_i.norm_x, ny: vtx_in_i.norm_y, nz: vtx_in_i.norm_z};
  assign v0 = held0_q;
  assign v1 = held1_q;
  // unused axis code compares z
  assign ax = (clip_axis_i == 2'd3) ? AXIS_Z : clip_axis_i;

  always_comb begin
    above[0] = axis_coord(v0, ax) > clip_value_i;
    above[1] = axis_coord(v1, ax) > clip_value_i;
    above[2] = axis_coord(cur, ax) > clip_value_i;
    n_above  = 2'($countones(above));
    if (above == 3'b111) begin
      n_above = 2'd3;
    end
    // corner a is the one not above whose successor is above
    rot = 2'd0;
    if (!above[1] && above[2]) begin
      rot = 2'd1;
    end
    if (!above[2] && above[0]) begin
      rot = 2'd2;
    end

    job.axis  = ax;
    job.value = clip_value_i;
    unique case (rot)
      2'd1:    begin job.a = v1;  job.b = cur; job.c = v0;  end
      2'd2:    begin job.a = cur; job.b = v0;  job.c = v1;  end
      default: begin job.a = v0;  job.b = v1;  job.c = cur; end
    endcase

    drop     = 1'b0;
    job.mode = MODE_PASS;
    priority if (above == 3'b000) begin
      drop = !keep_below_i;
      job.a = v0; job.b = v1; job.c = cur;
    end else if (above == 3'b111) begin
      drop = keep_below_i;
      job.a = v0; job.b = v1; job.c = cur;
    end else if (n_above == 2'd1) begin
      job.mode = keep_below_i ? MODE_ONE_BELOW : MODE_ONE_ABOVE;
    end else begin
      job.mode = keep_below_i ? MODE_TWO_BELOW : MODE_TWO_ABOVE;
    end
  end

  assign in_fire        = vtx_in_i.valid && vtx_in_i.ready;
  assign vtx_in_i.ready = (cnt_q != 2'd2) || job_ready_i;
  assign job_valid_o    = vtx_in_i.valid && (cnt_q == 2'd2) && !drop;
  assign job_o          = job;
  assign stat_o         = '{count: cnt_q, push: job_valid_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_fire) begin
      cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && cnt_q == 2'd0) begin
      held0_q <= cur;
    end
    if (in_fire && cnt_q == 2'd1) begin
      held1_q <= cur;
    end
  end

endmodule

/* rtl/tapc_back.sv */
// ----------------------------------------------------------------------------
// tapc_back: clip engine and vertex emitter
// Builds the new corners on the plane and streams out the result vertices.
// ----------------------------------------------------------------------------
module tapc_back import tapc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned JobBits = job_bits(COORD_BITS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  logic [JobBits-1:0] job_i,
  tapc_vtx_out_if.source     vtx_out_o
);

  localparam int unsigned EW       = ((COORD_BITS > NORM_BITS) ? COORD_BITS : NORM_BITS) + 1;
  localparam int unsigned MagW     = EW + T_BITS;
  localparam int unsigned SqW      = LEN2_BITS + NRM_SHIFT;
  localparam int unsigned DivdT    = COORD_BITS + T_FRAC + 1;
  localparam int unsigned DivdN    = NRM_SHIFT + NORM_BITS;
  localparam int unsigned DivdBits = (DivdT > DivdN) ? DivdT : DivdN;
  localparam int unsigned DvsrBits = (COORD_BITS > ROOT_BITS) ? COORD_BITS : ROOT_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic signed [NORM_BITS-1:0]  nx;
    logic signed [NORM_BITS-1:0]  ny;
    logic signed [NORM_BITS-1:0]  nz;
  } vtx_t;

  typedef struct packed {
    vtx_t                         a;
    vtx_t                         b;
    vtx_t                         c;
    mode_e                        mode;
    logic [1:0]                   axis;
    logic signed [COORD_BITS-1:0] value;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_START,
    ST_T_WAIT,
    ST_MUL,
    ST_ADD,
    ST_SQ,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_NRM_START,
    ST_NRM_WAIT,
    ST_CORNER_DONE,
    ST_EMIT
  } state_e;

  function automatic logic [EW-1:0] comp(vtx_t v, logic [2:0] k);
    logic [EW-1:0] r;
    unique case (k)
      3'd0:    r = EW'(v.px);
      3'd1:    r = EW'(v.py);
      3'd2:    r = EW'(v.pz);
      3'd3:    r = EW'(v.nx);
      3'd4:    r = EW'(v.ny);
      default: r = EW'(v.nz);
    endcase
    return r;
  endfunction

  state_e            state_q;
  job_t              job_q;
  logic              corner_q;
  logic [2:0]        k_q;
  logic [2:0]        idx_q;
  logic [T_BITS-1:0] t_q;
  logic [MagW-1:0]   mag_q;
  logic [EW-1:0]     pk_q;
  logic              dneg_q;
  logic [EW-1:0]     cv_q [6];
  logic [LEN2_BITS-1:0] sq_q;
  logic [LEN2_BITS-1:0] len_q;
  logic [SqW-1:0]    x_q;
  logic [SqW-1:0]    r_q;
  logic [SqW-1:0]    bit_q;
  vtx_t              pv_q;
  vtx_t              qv_q;
  logic              out_valid_q;
  vtx_t              out_q;
  logic              out_new_q;
  logic              out_last_q;

  job_t                 job_in;
  logic                 is_one;
  vtx_t                 ep_p;
  vtx_t                 ep_q;
  logic [EW-1:0]        pa;
  logic [EW-1:0]        qa;
  logic signed [EW-1:0] f_num;
  logic signed [EW-1:0] f_den;
  logic [COORD_BITS-1:0] t_n;
  logic [COORD_BITS-1:0] t_d;
  logic [EW-1:0]        pk;
  logic [EW-1:0]        dk;
  logic [EW-1:0]        dabs;
  logic [MagW-1:0]      rnd;
  logic [EW-1:0]        res;
  logic                 neg3;
  logic [NORM_BITS-1:0] m3;
  logic [ROOT_BITS-1:0] s;
  logic [SqW-1:0]       rb;
  logic [NORM_BITS-1:0] qc;
  logic [EW-1:0]        newn;
  vtx_t                 built;
  slot_e                slot;
  vtx_t                 sel;
  logic                 div_start;
  logic [DivdBits-1:0]  div_dividend;
  logic [DvsrBits-1:0]  div_divisor;
  logic                 div_done;
  logic [T_BITS-1:0]    div_quot;
  logic                 out_load;

  assign job_in      = job_i;
  assign job_ready_o = state_q == ST_IDLE;

  always_comb begin
    is_one = job_q.mode == MODE_ONE_BELOW || job_q.mode == MODE_ONE_ABOVE;
    ep_p   = (corner_q && is_one) ? job_q.b : job_q.a;
    ep_q   = corner_q ? job_q.c : job_q.b;

    // clip fraction, clamped to [0,1]
    pa    = comp(ep_p, {1'b0, job_q.axis});
    qa    = comp(ep_q, {1'b0, job_q.axis});
    f_num = signed'(EW'(job_q.value) - pa);
    f_den = signed'(qa - pa);
    if (f_den < 0) begin
      f_num = -f_num;
      f_den = -f_den;
    end
    if (f_num < 0) begin
      f_num = '0;
    end else if (f_num > f_den) begin
      f_num = f_den;
    end
    t_n = f_num[COORD_BITS-1:0];
    t_d = f_den[COORD_BITS-1:0];

    // interpolation of component k
    pk   = comp(ep_p, k_q);
    dk   = comp(ep_q, k_q) - pk;
    dabs = dk[EW-1] ? -dk : dk;
    rnd  = (mag_q + (MagW'(1) << (T_FRAC - 1))) >> T_FRAC;
    res  = dneg_q ? pk_q - rnd[EW-1:0] : pk_q + rnd[EW-1:0];
    if (k_q < 3'd3 && k_q[1:0] == job_q.axis) begin
      res = EW'(job_q.value);
    end

    // renormalization operands
    neg3 = cv_q[3][EW-1];
    m3   = neg3 ? NORM_BITS'(-cv_q[3]) : NORM_BITS'(cv_q[3]);
    s    = r_q[ROOT_BITS-1:0];
    rb   = r_q + bit_q;
    qc   = (div_quot > T_BITS'(UNIT_LEN)) ? NORM_BITS'(UNIT_LEN) : div_quot[NORM_BITS-1:0];
    newn = neg3 ? -EW'(qc) : EW'(qc);

    built.px = cv_q[0][COORD_BITS-1:0];
    built.py = cv_q[1][COORD_BITS-1:0];
    built.pz = cv_q[2][COORD_BITS-1:0];
    built.nx = cv_q[3][NORM_BITS-1:0];
    built.ny = cv_q[4][NORM_BITS-1:0];
    built.nz = cv_q[5][NORM_BITS-1:0];

    slot = mode_slot(job_q.mode, idx_q);
    unique case (slot)
      SLOT_B:  sel = job_q.b;
      SLOT_C:  sel = job_q.c;
      SLOT_P:  sel = pv_q;
      SLOT_Q:  sel = qv_q;
      default: sel = job_q.a;
    endcase

    div_start = state_q == ST_T_START || state_q == ST_NRM_START;
    if (state_q == ST_T_START) begin
      div_dividend = DivdBits'({t_n, {T_FRAC{1'b0}}}) + DivdBits'(t_d >> 1);
      div_divisor  = DvsrBits'(t_d);
    end else begin
      div_dividend = DivdBits'({m3, {NRM_SHIFT{1'b0}}}) + DivdBits'(s >> 1);
      div_divisor  = DvsrBits'(s);
    end
  end

  assign out_load = state_q == ST_EMIT && (!out_valid_q || vtx_out_o.ready);

  tapc_div #(
    .DivdBits(DivdBits),
    .DvsrBits(DvsrBits),
    .QuotBits(T_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      corner_q    <= 1'b0;
      k_q         <= '0;
      idx_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (vtx_out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            corner_q <= 1'b0;
            idx_q    <= '0;
            state_q  <= (job_in.mode == MODE_PASS) ? ST_EMIT : ST_T_START;
          end
        end
        ST_T_START: state_q <= ST_T_WAIT;
        ST_T_WAIT: begin
          if (div_done) begin
            k_q     <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_ADD;
        ST_ADD: begin
          if (k_q == 3'd5) begin
            k_q     <= '0;
            state_q <= ST_SQ;
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= ST_MUL;
          end
        end
        ST_SQ: begin
          if (k_q == 3'd3) begin
            state_q <= ST_ROOT_INIT;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_ROOT_INIT: state_q <= (len_q == '0) ? ST_CORNER_DONE : ST_ROOT;
        ST_ROOT: begin
          if (bit_q[0]) begin
            k_q     <= '0;
            state_q <= ST_NRM_START;
          end
        end
        ST_NRM_START: state_q <= ST_NRM_WAIT;
        ST_NRM_WAIT: begin
          if (div_done) begin
            k_q     <= k_q + 3'd1;
            state_q <= (k_q == 3'd2) ? ST_CORNER_DONE : ST_NRM_START;
          end
        end
        ST_CORNER_DONE: begin
          corner_q <= 1'b1;
          state_q  <= corner_q ? ST_EMIT : ST_T_START;
        end
        ST_EMIT: begin
          if (out_load) begin
            if (idx_q == mode_len(job_q.mode) - 3'd1) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) begin
      job_q <= job_in;
    end
    if (state_q == ST_T_WAIT && div_done) begin
      t_q <= div_quot;
    end
    if (state_q == ST_MUL) begin
      mag_q  <= MagW'(dabs) * MagW'(t_q);
      pk_q   <= pk;
      dneg_q <= dk[EW-1];
    end
    // shift in each interpolated component
    if (state_q == ST_ADD) begin
      cv_q[0] <= cv_q[1];
      cv_q[1] <= cv_q[2];
      cv_q[2] <= cv_q[3];
      cv_q[3] <= cv_q[4];
      cv_q[4] <= cv_q[5];
      cv_q[5] <= res;
      len_q   <= '0;
    end
    // rotate the normal through tap three while summing squares
    if (state_q == ST_SQ) begin
      if (k_q != 3'd3) begin
        sq_q    <= LEN2_BITS'(m3) * LEN2_BITS'(m3);
        cv_q[3] <= cv_q[4];
        cv_q[4] <= cv_q[5];
        cv_q[5] <= cv_q[3];
      end
      if (k_q != 3'd0) begin
        len_q <= len_q + sq_q;
      end
    end
    if (state_q == ST_ROOT_INIT) begin
      x_q   <= {len_q, {NRM_SHIFT{1'b0}}};
      r_q   <= '0;
      bit_q <= SqW'(1) << (SqW - 2);
      if (len_q == '0) begin
        cv_q[3] <= '0;
        cv_q[4] <= '0;
        cv_q[5] <= '0;
      end
    end
    if (state_q == ST_ROOT) begin
      if (x_q >= rb) begin
        x_q <= x_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (state_q == ST_NRM_WAIT && div_done) begin
      cv_q[3] <= cv_q[4];
      cv_q[4] <= cv_q[5];
      cv_q[5] <= newn;
    end
    if (state_q == ST_CORNER_DONE) begin
      if (corner_q) begin
        qv_q <= built;
      end else begin
        pv_q <= built;
      end
    end
    if (out_load) begin
      out_q      <= sel;
      out_new_q  <= slot == SLOT_P || slot == SLOT_Q;
      out_last_q <= idx_q == mode_len(job_q.mode) - 3'd1;
    end
  end

  assign vtx_out_o.valid         = out_valid_q;
  assign vtx_out_o.out_x         = out_q.px;
  assign vtx_out_o.out_y         = out_q.py;
  assign vtx_out_o.out_z         = out_q.pz;
  assign vtx_out_o.out_nx        = out_q.nx;
  assign vtx_out_o.out_ny        = out_q.ny;
  assign vtx_out_o.out_nz        = out_q.nz;
  assign vtx_out_o.is_new_corner = out_new_q;
  assign vtx_out_o.last          = out_last_q;

endmodule

/* rtl/triangle_axis_plane_clipper_top.sv */
// ----------------------------------------------------------------------------
// triangle_axis_plane_clipper_top: clips triangles against one axis plane
// Vertex stream in, clipped vertex stream out, three setup registers.
// ----------------------------------------------------------------------------
// Usage:
//   vtx_in_i takes one vertex per item; every third vertex closes a triangle.
//   vtx_out_o delivers result vertices, three per output triangle; last marks
//   the final vertex of an input triangle, is_new_corner the corners on the
//   plane. cfg_i writes clip_axis (0), clip_value (1) and keep_below (2); it
//   is always ready and other indexes are ignored.
//   Input vertices are taken one per cycle, except a third vertex while the
//   job queue is full. A kept triangle goes from the queue straight to the
//   emitter and comes out one vertex per cycle while the receiver is ready.
//   A cut triangle builds two corners on the shared divider. A two-entry
//   job queue lets the collector take further vertices while a triangle is
//   being cut. Reset empties the held corners and the queue and loads
//   clip_axis x, clip_value 16384 and keep_below 1. When the receiver stalls,
//   the output vertex holds, the clip engine waits and the queue fills, then
//   input ready drops on the third vertex of the next triangle.
// ----------------------------------------------------------------------------
module triangle_axis_plane_clipper_top import tapc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tapc_cfg_if.sink       cfg_i,
  tapc_vtx_in_if.sink    vtx_in_i,
  tapc_vtx_out_if.source vtx_out_o
);

  localparam int unsigned JobBits = job_bits(COORD_BITS);

  logic [1:0]                   clip_axis_q;
  logic signed [COORD_BITS-1:0] clip_value_q;
  logic                         keep_below_q;

  logic               job_push_valid;
  logic               job_push_ready;
  logic [JobBits-1:0] job_push_data;
  logic               job_pop_valid;
  logic               job_pop_ready;
  logic [JobBits-1:0] job_pop_data;
  front_stat_t        front_stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_axis_q  <= AXIS_X;
      clip_value_q <= COORD_BITS'(CLIP_VALUE_RST);
      keep_below_q <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_CLIP_AXIS:  clip_axis_q  <= cfg_i.wr_data[1:0];
        REG_CLIP_VALUE: clip_value_q <= COORD_BITS'(cfg_i.wr_data);
        REG_KEEP_BELOW: keep_below_q <= cfg_i.wr_data[0];
        default: ;
      endcase
    end
  end

  tapc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_in_i    (vtx_in_i),
    .clip_axis_i (clip_axis_q),
    .clip_value_i(clip_value_q),
    .keep_below_i(keep_below_q),
    .job_valid_o (job_push_valid),
    .job_ready_i (job_push_ready),
    .job_o       (job_push_data),
    .stat_o      (front_stat)
  );

  tapc_queue #(
    .Width(JobBits),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(job_push_valid),
    .push_ready_o(job_push_ready),
    .push_data_i (job_push_data),
    .pop_valid_o (job_pop_valid),
    .pop_ready_i (job_pop_ready),
    .pop_data_o  (job_pop_data)
  );

  tapc_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_pop_valid),
    .job_ready_o(job_pop_ready),
    .job_i      (job_pop_data),
    .vtx_out_o  (vtx_out_o)
  );

  // a job is offered only while a closing vertex is on the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.push |-> (vtx_in_i.valid && front_stat.count == 2'd2))
    else $error("job offered without a closing vertex");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx_in_i.valid && vtx_in_i.ready && front_stat.count == 2'd2)
      |=> front_stat.count == 2'd0)
    else $error("corner count did not restart after a triangle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.count != 2'd3)
    else $error("corner count out of range");

endmodule

/* verif/tb_triangle_axis_plane_clipper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for triangle_axis_plane_clipper_top
// Sends vertex triangles through the clipper under several plane settings,
// predicts every result vertex and compares the returned stream field by field.
// ----------------------------------------------------------------------------
module tb_triangle_axis_plane_clipper_top;
  import tapc_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [15:0] x, y, z, nx, ny, nz;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] x, y, z, nx, ny, nz;
    logic fresh;
    logic last;
  } out_vtx_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tapc_cfg_if #(.DataBits(CB)) cfg_ch ();
  tapc_vtx_in_if #(.CoordBits(CB)) in_ch ();
  tapc_vtx_out_if #(.CoordBits(CB)) out_ch ();

  triangle_axis_plane_clipper_top #(.COORD_BITS(CB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_i(cfg_ch.sink), .vtx_in_i(in_ch.sink), .vtx_out_o(out_ch.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [1:0] axis_sel = AXIS_X;
  logic signed [15:0] plane_value = 16'sd16384;
  logic keep_low = 1'b1;
  vertex_t held [2];
  int held_count = 0;

  vertex_t pending_vertices [$];
  out_vtx_t expected_vertices [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stall_hold = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  bit long_gaps = 1'b1;

  function automatic longint coord_of(vertex_t v, int ax);
    if (ax == 0) return v.x;
    if (ax == 1) return v.y;
    return v.z;
  endfunction

  function automatic longint unsigned cut_fraction(longint num, longint den);
    longint unsigned n, d;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num < 0) num = 0;
    if (num > den) num = den;
    n = num;
    d = den;
    return ((n << T_FRAC) + d / 2) / d;
  endfunction

  function automatic longint blend(longint a, longint b, longint unsigned t);
    longint d;
    longint unsigned mag, r;
    d = b - a;
    mag = longint'(d < 0 ? -d : d) * t;
    r = (mag + (64'd1 << (T_FRAC - 1))) >> T_FRAC;
    return d < 0 ? a - longint'(r) : a + longint'(r);
  endfunction

  function automatic longint unsigned root_of(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_vtx_t plane_corner(vertex_t p, vertex_t q, int ax, longint value);
    longint pc [6];
    longint qc [6];
    longint rc [6];
    longint unsigned t, len2, s, m, quo;
    out_vtx_t o;
    pc = '{p.x, p.y, p.z, p.nx, p.ny, p.nz};
    qc = '{q.x, q.y, q.z, q.nx, q.ny, q.nz};
    t = cut_fraction(value - pc[ax], qc[ax] - pc[ax]);
    for (int k = 0; k < 6; k++) rc[k] = blend(pc[k], qc[k], t);
    rc[ax] = value;
    len2 = 0;
    for (int k = 3; k < 6; k++) begin
      m = rc[k] < 0 ? -rc[k] : rc[k];
      len2 += m * m;
    end
    if (len2 == 0) begin
      rc[3] = 0; rc[4] = 0; rc[5] = 0;
    end else begin
      s = root_of(len2 << NRM_SHIFT);
      for (int k = 3; k < 6; k++) begin
        m = rc[k] < 0 ? -rc[k] : rc[k];
        quo = ((m << NRM_SHIFT) + s / 2) / s;
        if (quo > UNIT_LEN) quo = UNIT_LEN;
        rc[k] = rc[k] < 0 ? -longint'(quo) : longint'(quo);
      end
    end
    o.x = 16'(rc[0]); o.y = 16'(rc[1]); o.z = 16'(rc[2]);
    o.nx = 16'(rc[3]); o.ny = 16'(rc[4]); o.nz = 16'(rc[5]);
    o.fresh = 1'b1;
    o.last = 1'b0;
    return o;
  endfunction

  function automatic out_vtx_t corner_out(vertex_t v);
    out_vtx_t o;
    o = {v.x, v.y, v.z, v.nx, v.ny, v.nz, 1'b0, 1'b0};
    return o;
  endfunction

  task automatic predict_clip(vertex_t cur);
    vertex_t v [3];
    bit above [3];
    int ax, cnt, r;
    longint value;
    out_vtx_t a, b, c, p, q;
    out_vtx_t res [$];
    if (held_count < 2) begin
      held[held_count] = cur;
      held_count++;
      return;
    end
    held_count = 0;
    ax = axis_sel > AXIS_Z ? 2 : axis_sel;
    value = plane_value;
    v = '{held[0], held[1], cur};
    cnt = 0;
    r = 0;
    for (int i = 0; i < 3; i++) begin
      above[i] = coord_of(v[i], ax) > value;
      cnt += above[i];
    end
    if ((cnt == 0 && keep_low) || (cnt == 3 && !keep_low)) begin
      for (int i = 0; i < 3; i++) res = {res, corner_out(v[i])};
    end else if (cnt != 0 && cnt != 3) begin
      for (int i = 0; i < 3; i++)
        if (!above[i] && above[(i + 1) % 3]) r = i;
      a = corner_out(v[r]);
      b = corner_out(v[(r + 1) % 3]);
      c = corner_out(v[(r + 2) % 3]);
      p = plane_corner(v[r], v[(r + 1) % 3], ax, value);
      if (cnt == 1) begin
        q = plane_corner(v[(r + 1) % 3], v[(r + 2) % 3], ax, value);
        if (keep_low) res = '{a, p, q, a, q, c};
        else res = '{p, b, q};
      end else begin
        q = plane_corner(v[r], v[(r + 2) % 3], ax, value);
        if (keep_low) res = '{a, p, q};
        else res = '{p, b, q, q, b, c};
      end
    end
    foreach (res[i]) begin
      res[i].last = (i == res.size() - 1);
      expected_vertices = {expected_vertices, res[i]};
    end
  endtask

  // stimulus driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.pos_x <= '0; in_ch.pos_y <= '0; in_ch.pos_z <= '0;
      in_ch.norm_x <= '0; in_ch.norm_y <= '0; in_ch.norm_z <= '0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_vertices.size() > 0) begin
        vertex_t nv;
        nv = pending_vertices.pop_front();
        in_ch.valid <= 1'b1;
        {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.norm_x, in_ch.norm_y,
         in_ch.norm_z} <= nv;
        if ($urandom_range(0, 3) == 0)
          send_gap <= (long_gaps && $urandom_range(0, 9) == 0) ?
                      $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else if (stall_hold) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (long_gaps && $urandom_range(0, 4) == 0)
        recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                    $urandom_range(1, 3);
    end
  end

  // input predictor, output checker, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        predict_clip({in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.norm_x,
                      in_ch.norm_y, in_ch.norm_z});
      if (out_ch.valid && out_ch.ready) begin
        out_vtx_t got, want;
        got = {out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_nx,
               out_ch.out_ny, out_ch.out_nz, out_ch.is_new_corner, out_ch.last};
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected vertex %h", got);
        end else begin
          want = expected_vertices.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("vertex mismatch: expected %h got %h", want, got);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("triangle_axis_plane_clipper_top verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_CLIP_AXIS) axis_sel = data[1:0];
    else if (idx == REG_CLIP_VALUE) plane_value = data;
    else if (idx == REG_KEEP_BELOW) keep_low = data[0];
    // leave the channel idle before the next write
    @(posedge clk_i);
  endtask

  task automatic drain;
    while (pending_vertices.size() > 0 || in_ch.valid || expected_vertices.size() > 0)
      @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  function automatic vertex_t random_vertex();
    vertex_t v;
    v = {$urandom, $urandom, $urandom};
    return v;
  endfunction

  // vertex near the plane so that cuts stay frequent
  function automatic vertex_t near_vertex();
    vertex_t v;
    int ax;
    longint c;
    v = random_vertex();
    ax = axis_sel > AXIS_Z ? 2 : axis_sel;
    c = longint'(plane_value) + $signed($urandom_range(0, 8000)) - 4000;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 1) ? 32767 : -32768;
    if (ax == 0) v.x = 16'(c);
    else if (ax == 1) v.y = 16'(c);
    else v.z = 16'(c);
    if ($urandom_range(0, 9) == 0) begin
      v.nx = '0; v.ny = '0; v.nz = '0;
    end
    return v;
  endfunction

  function automatic vertex_t at_x(logic signed [15:0] x, logic signed [15:0] n);
    vertex_t v;
    v = {x, 16'sd100, -16'sd100, n, -n, 16'sd0};
    return v;
  endfunction

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = REG_CLIP_AXIS;
    cfg_ch.wr_data = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset plane x = 16384 keeping below
    pending_vertices = '{
      at_x(0, 100), at_x(100, 200), at_x(-200, 300),                // pass
      at_x(32767, 1), at_x(20000, 2), at_x(30000, 3),               // dropped
      at_x(0, 16384), at_x(32767, -16384), at_x(-32768, 5),         // one above
      at_x(32767, 7), at_x(0, -7), at_x(30000, 7),                  // two above
      at_x(0, 100), at_x(32767, -100), at_x(16384, 50),             // on-plane corner, zero normal
      {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
      {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
      {16'sh0000, 16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001, 16'sh0000}};
    drain();
    write_reg(REG_KEEP_BELOW, 16'd0);
    pending_vertices = '{at_x(0, 100), at_x(32767, -100), at_x(-32768, 5),
                         at_x(32767, 7), at_x(0, -7), at_x(30000, 7)};
    drain();
    write_reg(REG_UNUSED, 16'hffff);  // unused index, ignored
    write_reg(REG_CLIP_AXIS, 16'd3);  // axis code 3 behaves as z
    write_reg(REG_CLIP_VALUE, 16'h8000);
    for (int k = 0; k < 6; k++) pending_vertices = {pending_vertices, near_vertex()};
    drain();

    // random phases through several plane settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CLIP_AXIS, 16'(ph % 4));
      write_reg(REG_CLIP_VALUE, ph == 1 ? 16'h7fff : ph == 2 ? 16'h8000 : 16'($urandom));
      write_reg(REG_KEEP_BELOW, 16'(ph[0]));
      long_gaps = (ph != 3);
      for (int k = 0; k < 54; k++)
        pending_vertices = {pending_vertices,
                            ($urandom_range(0, 5) == 0) ? random_vertex() : near_vertex()};
      if (ph == 5) begin
        // hold the receiver off so the job queue fills and input stalls
        stall_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        stall_hold = 1'b0;
      end
      drain();
    end

    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("triangle_axis_plane_clipper_top verification clean");
    end else begin
      $display("triangle_axis_plane_clipper_top verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tapc_pkg.sv
rtl/tapc_if.sv
rtl/tapc_div.sv
rtl/tapc_queue.sv
rtl/tapc_front.sv
rtl/tapc_back.sv
rtl/triangle_axis_plane_clipper_top.sv
verif/tb_triangle_axis_plane_clipper_top.sv
